// ===== hw/rtl/sbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_pkg: shared types and constants of the scaler bank decoder
// Parse phases, result status codes, register map and stream layout.
// ----------------------------------------------------------------------------
package sbd_pkg;

  localparam int unsigned CHANNELS_DEF = 32;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MARKER_W = 16;
  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned FLAG_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 3;

  localparam logic [MARKER_W-1:0] MARKER_RESET = 16'hFB0B;

  localparam int unsigned FLAG_LSB   = 4;
  localparam int unsigned COUNT_MSB  = 2;
  localparam logic [POS_W-1:0] POS_FLAGS = 3'd3;
  localparam logic [POS_W-1:0] POS_STAMP = 3'd4;
  localparam logic [POS_W-1:0] POS_SAT   = 3'd7;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_MARKER = 1'b0;

  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned S_FIRST_BIT = 0;
  localparam int unsigned S_CRATE_BIT = 1;
  localparam int unsigned M_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 144;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_SEEK,
    PH_HDR,
    PH_COUNT,
    PH_DONE
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CHANNEL    = 2'd0,
    ST_NO_MARKER  = 2'd1,
    ST_TRUNCATED  = 2'd2,
    ST_ZERO_COUNT = 2'd3
  } status_e;

  typedef struct packed {
    logic [WORD_W-1:0] time_stamp;
    logic              gate_bit;
    logic              quartet_bit;
    logic              helicity_bit;
    logic [WORD_W-1:0] minus_count;
    logic [WORD_W-1:0] plus_count;
    logic [SUM_W-1:0]  channel_sum;
    logic [CHAN_W-1:0] channel;
  } result_t;

endpackage

// ===== hw/rtl/scaler_bank_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaler_bank_decoder: readout bank scaler decoder
// Parses one bank word per transfer and emits per-channel helicity counts and status results.
// ----------------------------------------------------------------------------
// The decoder takes one bank word in every clock cycle and produces at most
// one result per word, registered in the cycle after the word is taken. Results wait in an
// output register; input is held off only while that register is full and
// the downstream side does not take it. The first scaler block lives in a
// CHANNELS-deep RAM with registered read; the read address runs one word
// ahead of the channel counter, so each second-block count meets its stored
// plus count as it arrives. No RAM clearing pass is needed after reset.
module scaler_bank_decoder
  import sbd_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WORD_W-1:0]    s_axis_tdata,   // [31:0] raw_word
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // [0] bank_first, [1] crate_select
  input  logic                 s_axis_tlast,   // bank_last
  // stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [4:0] channel, [37:5] channel_sum, [69:38] plus_count, [101:70] minus_count,
  // [102] helicity_bit, [103] quartet_bit, [104] gate_bit, [136:105] time_stamp
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [M_TUSER_W-1:0] m_axis_tuser,   // [1:0] status, [2] crate_id
  output logic                 m_axis_tlast,   // last_channel
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int unsigned CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHANNELS - 1);

  logic [MARKER_W-1:0] marker_q;

  phase_e            phase_q, phase_d, phase_cur;
  logic [POS_W-1:0]  pos_q, pos_d, pos_cur;
  logic [FLAG_W-1:0] flags_q, flags_d;
  logic [WORD_W-1:0] stamp_q, stamp_d;
  logic              blk_q, blk_d, blk_cur;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_cur;
  logic              crate_q, crate_d;

  logic              acc, first, last;
  logic              marker_hit;
  logic              mem_we;
  logic [WORD_W-1:0] plus_rd;

  logic              res_valid;
  status_e           res_status;
  logic              res_last;
  result_t           res;

  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_crate_q;
  logic              out_last_q;
  result_t           out_res_q;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MARKER) ? PDATA_W'(marker_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= MARKER_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MARKER) begin
      marker_q <= pwdata[MARKER_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign first         = s_axis_tuser[S_FIRST_BIT];
  assign last          = s_axis_tlast;
  assign marker_hit    = s_axis_tdata[WORD_W-1:WORD_W-MARKER_W] == marker_q;

  assign phase_cur = first ? PH_HEAD : phase_q;
  assign pos_cur   = first ? '0 : pos_q;
  assign blk_cur   = first ? 1'b0 : blk_q;
  assign cnt_cur   = first ? '0 : cnt_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    stamp_d = stamp_q;
    blk_d   = blk_q;
    cnt_d   = cnt_q;
    crate_d = crate_q;
    mem_we  = 1'b0;
    if (acc) begin
      if (first) begin
        phase_d = PH_HEAD;
        pos_d   = '0;
        flags_d = '0;
        stamp_d = '0;
        blk_d   = 1'b0;
        cnt_d   = '0;
        crate_d = s_axis_tuser[S_CRATE_BIT];
      end
      unique case (phase_cur)
        PH_IDLE: begin
        end
        PH_DONE: begin
          if (last) begin
            phase_d = PH_IDLE;
          end
        end
        PH_HEAD: begin
          if (pos_cur == POS_FLAGS) begin
            flags_d = s_axis_tdata[FLAG_LSB +: FLAG_W];
          end
          if (pos_cur == POS_STAMP) begin
            stamp_d = s_axis_tdata;
            phase_d = PH_SEEK;
          end
        end
        PH_SEEK: begin
          if (marker_hit) begin
            if (s_axis_tdata[COUNT_MSB:0] == '0) begin
              phase_d = PH_DONE;
            end else begin
              blk_d   = 1'b0;
              phase_d = PH_HDR;
            end
          end
        end
        PH_HDR: begin
          cnt_d   = '0;
          phase_d = PH_COUNT;
        end
        PH_COUNT: begin
          if (!blk_cur) begin
            mem_we = 1'b1;
            if (cnt_cur == CNT_LAST) begin
              blk_d   = 1'b1;
              cnt_d   = '0;
              phase_d = PH_HDR;
            end else begin
              cnt_d = cnt_cur + 1'b1;
            end
          end else begin
            cnt_d = cnt_cur + 1'b1;
            if (cnt_cur == CNT_LAST) begin
              phase_d = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
      if (phase_cur != PH_IDLE && phase_cur != PH_DONE) begin
        pos_d = (pos_cur == POS_SAT) ? pos_cur : pos_cur + 1'b1;
        if (last) begin
          phase_d = PH_IDLE;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  always_comb begin
    res_valid    = 1'b0;
    res_status   = ST_CHANNEL;
    res_last     = 1'b1;
    res          = '0;
    res.time_stamp   = stamp_d;
    res.helicity_bit = flags_d[0];
    res.quartet_bit  = flags_d[1];
    res.gate_bit     = flags_d[2];
    if (acc) begin
      unique case (phase_cur)
        PH_SEEK: begin
          if (marker_hit && s_axis_tdata[COUNT_MSB:0] == '0) begin
            res_valid  = 1'b1;
            res_status = ST_ZERO_COUNT;
          end
        end
        PH_COUNT: begin
          if (blk_cur) begin
            res_valid       = 1'b1;
            res_last        = cnt_cur == CNT_LAST;
            res.channel     = CHAN_W'(cnt_cur);
            res.plus_count  = plus_rd;
            res.minus_count = s_axis_tdata;
            res.channel_sum = SUM_W'(plus_rd) + SUM_W'(s_axis_tdata);
          end
        end
        default: begin
        end
      endcase
      if (last && !res_last) begin
        res = '0;
        res.time_stamp   = stamp_d;
        res.helicity_bit = flags_d[0];
        res.quartet_bit  = flags_d[1];
        res.gate_bit     = flags_d[2];
        res_status = ST_TRUNCATED;
        res_last   = 1'b1;
      end else if (last && !res_valid) begin
        if (phase_d == PH_IDLE && phase_cur != PH_IDLE && phase_cur != PH_DONE) begin
          res_valid = 1'b1;
          res_status = (phase_cur == PH_HEAD || (phase_cur == PH_SEEK && !marker_hit)) ?
                       ST_NO_MARKER : ST_TRUNCATED;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // First block store
  // --------------------------------------------------------------------------
  sbd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_cur),
    .wdata_i (s_axis_tdata),
    .raddr_i (cnt_d),
    .rdata_o (plus_rd)
  );

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      flags_q     <= '0;
      stamp_q     <= '0;
      blk_q       <= 1'b0;
      cnt_q       <= '0;
      crate_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      stamp_q <= stamp_d;
      blk_q   <= blk_d;
      cnt_q   <= cnt_d;
      crate_q <= crate_d;
      if (acc && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && res_valid) begin
      out_status_q <= res_status;
      out_crate_q  <= crate_d;
      out_last_q   <= res_last;
      out_res_q    <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_res_q);
  assign m_axis_tuser  = {out_crate_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  a_status_has_no_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[STATUS_W-1:0] != ST_CHANNEL |->
      m_axis_tlast && m_axis_tdata[SUM_W+CHAN_W-1:0] == '0)
    else $error("status result carries channel data");

  a_final_channel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[STATUS_W-1:0] == ST_CHANNEL && m_axis_tlast |->
      m_axis_tdata[CHAN_W-1:0] == CHAN_W'(CHANNELS - 1))
    else $error("last channel result not on final channel");

  a_count_after_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !first && phase_q == PH_HDR && !last |=> phase_q == PH_COUNT && cnt_q == '0)
    else $error("block header did not start channel count");

endmodule

// ===== hw/rtl/sbd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbd_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
